// ----- hw/rtl/tep_pkg.sv -----
// Shared types and constants for the touch event to pointer unit.
package tep_pkg;

    localparam int COORD_BITS  = 12;
    localparam int SCALE_SHIFT = 12;
    localparam int VALUE_BITS  = 12;
    localparam int PROD_BITS   = 2 * VALUE_BITS;
    localparam int SAT_BITS    = 17;
    localparam int OUT_BITS    = 12;
    localparam int THR_BITS    = 8;
    localparam int QDepth      = 2;
    localparam int QPtrBits    = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntBits    = $clog2(QDepth + 1);

    localparam logic [COORD_BITS-1:0] CoordMax = {COORD_BITS{1'b1}};

    localparam logic [4:0] EVT_SYNC = 5'd0;
    localparam logic [4:0] EVT_KEY  = 5'd1;
    localparam logic [4:0] EVT_ABS  = 5'd3;

    localparam logic [9:0] CODE_X     = 10'h035;
    localparam logic [9:0] CODE_Y     = 10'h036;
    localparam logic [9:0] CODE_TOUCH = 10'h14a;
    localparam logic [9:0] CODE_DTAP  = 10'h14d;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    localparam logic [1:0] CFG_SCALE_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_SCREEN_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_MOVE_THRESHOLD = 2'd3;

    typedef enum logic [2:0] {
        OP_SET_X,
        OP_SET_Y,
        OP_TOUCH,
        OP_DTAP,
        OP_SYNC
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [COORD_BITS-1:0] pos;
        logic                  key_down;
    } item_t;

    typedef struct packed {
        logic                  scale_enable;
        logic [VALUE_BITS-1:0] screen_width;
        logic [VALUE_BITS-1:0] screen_height;
        logic [THR_BITS-1:0]   move_threshold;
    } cfg_t;

endpackage

// ----- hw/rtl/touch_event_to_pointer_unit.sv -----
// Top level: config registers, front decoder, item queue and back end.
// Throughput: one input beat per cycle unless a full queue holds the front
// register. The front register, a 2-entry queue and the output register lie
// in turn on the path and let input and output stall independently.
// Reset: config returns to scale off, 600 x 800, threshold 10; pointer state,
// flags, queue and output valid clear at once. No clearing pass.
module touch_event_to_pointer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  event_type,
    input  logic [9:0]  event_code,
    input  logic [11:0] event_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] point_x,
    output logic [11:0] point_y,
    output logic [1:0]  buttons
);
    import tep_pkg::*;

    cfg_t  cfg_reg;
    logic  push;
    item_t push_item;
    logic  q_full;
    logic  pop;
    logic  q_valid;
    item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_enable   <= 1'b0;
            cfg_reg.screen_width   <= 12'd600;
            cfg_reg.screen_height  <= 12'd800;
            cfg_reg.move_threshold <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE_ENABLE:   cfg_reg.scale_enable   <= cfg_data[0];
                CFG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_data;
                CFG_SCREEN_HEIGHT:  cfg_reg.screen_height  <= cfg_data;
                CFG_MOVE_THRESHOLD: cfg_reg.move_threshold <= cfg_data[THR_BITS-1:0];
            endcase
        end
    end

    tep_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    tep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    tep_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (pop_item),
        .pop            (pop),
        .move_threshold (cfg_reg.move_threshold),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .buttons        (buttons)
    );

endmodule

// ----- hw/rtl/tep_front.sv -----
// Front end: accepts event beats, decodes them and scales position samples when scaling is on.
module tep_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [4:0]      event_type,
    input  logic [9:0]      event_code,
    input  logic [11:0]     event_value,
    input  tep_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            push,
    output tep_pkg::item_t  push_item
);
    import tep_pkg::*;

    logic                  keep;
    item_t                 item;
    logic [VALUE_BITS-1:0] size;
    logic [PROD_BITS-1:0]  product;
    logic [VALUE_BITS-1:0] raw;
    logic [SAT_BITS-1:0]   raw_wide;
    logic                  valid_reg;
    logic                  valid_next;
    item_t                 item_reg;
    logic                  accept;

    always_comb
    begin
        size     = (event_code == CODE_X) ? cfg.screen_width : cfg.screen_height;
        product  = PROD_BITS'(size) * PROD_BITS'(event_value);
        raw      = cfg.scale_enable ? product[SCALE_SHIFT +: VALUE_BITS] : event_value;
        raw_wide = SAT_BITS'(raw);
        keep     = 1'b0;
        item.op  = OP_SYNC;
        item.key_down = (event_value != '0);
        if (raw_wide > SAT_BITS'(CoordMax))
        begin
            item.pos = CoordMax;
        end
        else
        begin
            item.pos = raw_wide[COORD_BITS-1:0];
        end
        priority if (event_type == EVT_ABS)
        begin
            keep    = (event_code == CODE_X) || (event_code == CODE_Y);
            item.op = (event_code == CODE_X) ? OP_SET_X : OP_SET_Y;
        end
        else if (event_type == EVT_KEY)
        begin
            keep    = (event_code == CODE_TOUCH) || (event_code == CODE_DTAP);
            item.op = (event_code == CODE_TOUCH) ? OP_TOUCH : OP_DTAP;
        end
        else if (event_type == EVT_SYNC)
        begin
            keep    = 1'b1;
            item.op = OP_SYNC;
        end
        else
        begin
            keep = 1'b0;
        end
    end

    assign push      = valid_reg && !q_full;
    assign in_ready  = !valid_reg || !q_full;
    assign accept    = in_valid && in_ready;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = keep;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && q_full |=> valid_reg && (item_reg == $past(item_reg)))
        else $error("front beat lost while queue full");

endmodule

// ----- hw/rtl/tep_queue.sv -----
// Short queue of decoded items between front and back.
module tep_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tep_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output tep_pkg::item_t  pop_item
);
    import tep_pkg::*;

    item_t                entry_reg [QDepth];
    logic [QPtrBits-1:0]  wr_ptr_reg;
    logic [QPtrBits-1:0]  rd_ptr_reg;
    logic [QCntBits-1:0]  count_reg;
    logic [QCntBits-1:0]  count_next;

    assign full     = (count_reg == QCntBits'(QDepth));
    assign q_valid  = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPtrBits'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPtrBits'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntBits'(QDepth))
        else $error("queue count overflow");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop) && !(pop && !q_valid))
        else $error("queue overrun or underrun");

endmodule

// ----- hw/rtl/tep_back.sv -----
// Back end: applies decoded items to pointer state and registers results.
module tep_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  tep_pkg::item_t  q_item,
    output logic            pop,
    input  logic [7:0]      move_threshold,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [11:0]     point_x,
    output logic [11:0]     point_y,
    output logic [1:0]      buttons
);
    import tep_pkg::*;

    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg, ref_x_reg, ref_y_reg;
    logic                  touch_now_reg, touch_pending_reg;
    logic                  dtap_now_reg, dtap_pending_reg;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   point_x_reg, point_y_reg;
    logic [1:0]            buttons_reg;

    logic [COORD_BITS-1:0] stored;
    logic [COORD_BITS-1:0] diff;
    logic                  move;
    logic                  moved;
    logic                  emit;
    logic [1:0]            emit_btn;

    always_comb
    begin
        stored = (q_item.op == OP_SET_X) ? cur_x_reg : cur_y_reg;
        diff   = (q_item.pos > stored) ? q_item.pos - stored : stored - q_item.pos;
        move   = (SAT_BITS'(diff) > SAT_BITS'(move_threshold));
        moved  = (cur_x_reg != ref_x_reg) || (cur_y_reg != ref_y_reg);
        emit     = 1'b0;
        emit_btn = BTN_NONE;
        unique case (q_item.op)
            OP_TOUCH:
            begin
                emit     = 1'b1;
                emit_btn = q_item.key_down ? BTN_LEFT : BTN_NONE;
            end
            OP_DTAP:
            begin
                emit     = 1'b1;
                emit_btn = q_item.key_down ? BTN_RIGHT : BTN_NONE;
            end
            OP_SYNC:
            begin
                emit     = !dtap_now_reg && !dtap_pending_reg && touch_now_reg
                           && touch_pending_reg && moved;
                emit_btn = BTN_LEFT;
            end
            default:
            begin
                emit     = 1'b0;
                emit_btn = BTN_NONE;
            end
        endcase
    end

    assign pop       = q_valid && (!emit || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign buttons   = buttons_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            ref_x_reg         <= '0;
            ref_y_reg         <= '0;
            touch_now_reg     <= 1'b0;
            touch_pending_reg <= 1'b0;
            dtap_now_reg      <= 1'b0;
            dtap_pending_reg  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                unique case (q_item.op)
                    OP_SET_X:
                    begin
                        if (move)
                        begin
                            cur_x_reg <= q_item.pos;
                        end
                    end
                    OP_SET_Y:
                    begin
                        if (move)
                        begin
                            cur_y_reg <= q_item.pos;
                        end
                    end
                    OP_TOUCH:
                    begin
                        touch_pending_reg <= q_item.key_down;
                    end
                    OP_DTAP:
                    begin
                        dtap_pending_reg <= q_item.key_down;
                    end
                    OP_SYNC:
                    begin
                        ref_x_reg     <= cur_x_reg;
                        ref_y_reg     <= cur_y_reg;
                        touch_now_reg <= touch_pending_reg;
                        dtap_now_reg  <= dtap_pending_reg;
                    end
                    default:
                    begin
                        ref_x_reg <= ref_x_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            point_x_reg <= OUT_BITS'(cur_x_reg);
            point_y_reg <= OUT_BITS'(cur_y_reg);
            buttons_reg <= emit_btn;
        end
    end

    a_btn_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (buttons_reg == BTN_NONE || buttons_reg == BTN_LEFT
                           || buttons_reg == BTN_RIGHT))
        else $error("bad button code");

    a_sync_commit: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.op == OP_SYNC |=> (ref_x_reg == cur_x_reg) && (ref_y_reg == cur_y_reg))
        else $error("sync did not commit reference point");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(pop && emit))
        else $error("result overwritten before taken");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for touch_event_to_pointer_unit with a pointer tracking scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import tep_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 120;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [1:0]  btn;
    } pointer_t;

    class pointer_tracker;
        logic        scale_on;
        logic [11:0] width;
        logic [11:0] height;
        logic [7:0]  thresh;
        logic [11:0] cur_x;
        logic [11:0] cur_y;
        logic [11:0] ref_x;
        logic [11:0] ref_y;
        bit          touch_now;
        bit          touch_pend;
        bit          dtap_now;
        bit          dtap_pend;
        pointer_t    pending_pointers[$];

        function new();
            scale_on   = 1'b0;
            width      = 12'd600;
            height     = 12'd800;
            thresh     = 8'd10;
            cur_x      = '0;
            cur_y      = '0;
            ref_x      = '0;
            ref_y      = '0;
            touch_now  = 0;
            touch_pend = 0;
            dtap_now   = 0;
            dtap_pend  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_SCALE_ENABLE:   scale_on = data[0];
                CFG_SCREEN_WIDTH:   width = data;
                CFG_SCREEN_HEIGHT:  height = data;
                CFG_MOVE_THRESHOLD: thresh = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] settle(logic [11:0] stored, logic [11:0] pos);
            logic [11:0] delta;
            delta = (pos > stored) ? pos - stored : stored - pos;
            return (delta > {4'd0, thresh}) ? pos : stored;
        endfunction

        function void post_pointer(logic [1:0] btn);
            pending_pointers.push_back('{x: cur_x, y: cur_y, btn: btn});
        endfunction

        function void note_event(logic [4:0] typ, logic [9:0] code, logic [11:0] val);
            logic [11:0] pos;
            logic [11:0] size;
            logic [23:0] prod;
            bit          moved;
            case (typ)
                EVT_ABS:
                begin
                    if (code == CODE_X || code == CODE_Y)
                    begin
                        pos = val;
                        if (scale_on)
                        begin
                            size = (code == CODE_X) ? width : height;
                            prod = 24'(size) * 24'(val);
                            pos  = prod[23:12];
                        end
                        if (code == CODE_X)
                            cur_x = settle(cur_x, pos);
                        else
                            cur_y = settle(cur_y, pos);
                    end
                end
                EVT_KEY:
                begin
                    if (code == CODE_TOUCH)
                    begin
                        touch_pend = (val != 0);
                        post_pointer(touch_pend ? BTN_LEFT : BTN_NONE);
                    end
                    else if (code == CODE_DTAP)
                    begin
                        dtap_pend = (val != 0);
                        post_pointer(dtap_pend ? BTN_RIGHT : BTN_NONE);
                    end
                end
                EVT_SYNC:
                begin
                    moved = (cur_x != ref_x) || (cur_y != ref_y);
                    if (!dtap_now && !dtap_pend && touch_now && touch_pend && moved)
                        post_pointer(BTN_LEFT);
                    ref_x     = cur_x;
                    ref_y     = cur_y;
                    touch_now = touch_pend;
                    dtap_now  = dtap_pend;
                end
                default: ;
            endcase
        endfunction

        function bit check_pointer(logic [11:0] x, logic [11:0] y, logic [1:0] btn,
                                   output string why);
            pointer_t want;
            why = "";
            if (pending_pointers.size() == 0)
            begin
                why = $sformatf("unexpected pointer beat x=%0d y=%0d btn=%0d", x, y, btn);
                return 0;
            end
            want = pending_pointers.pop_front();
            if (x !== want.x)
                why = {why, $sformatf(" x %0d/%0d", x, want.x)};
            if (y !== want.y)
                why = {why, $sformatf(" y %0d/%0d", y, want.y)};
            if (btn !== want.btn)
                why = {why, $sformatf(" btn %0d/%0d", btn, want.btn)};
            if (why != "")
                why = {"pointer beat mismatch (got/want):", why};
            return why == "";
        endfunction

        function int pending();
            return pending_pointers.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [4:0]  event_type;
    logic [9:0]  event_code;
    logic [11:0] event_value;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [1:0]  buttons;

    pointer_tracker tracker;
    int    errors;
    int    idle_cycles;
    int    live_sent;
    bit    send_steady;
    bit    take_steady;
    int    last_x;
    int    last_y;
    string why;

    touch_event_to_pointer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .buttons     (buttons)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (!tracker.check_pointer(point_x, point_y, buttons, why))
                    report(why);
            end
            if (in_valid && in_ready)
                tracker.note_event(event_type, event_code, event_value);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("touch_event_to_pointer_unit test failed");
                $finish;
            end
        end
    end

    // Result side: random stall before each beat, none while steady.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = take_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    function automatic bit is_live(logic [4:0] typ, logic [9:0] code);
        return typ == EVT_SYNC
            || (typ == EVT_KEY && (code == CODE_TOUCH || code == CODE_DTAP))
            || (typ == EVT_ABS && (code == CODE_X || code == CODE_Y));
    endfunction

    task automatic send_event(logic [4:0] typ, logic [9:0] code, logic [11:0] val);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (is_live(typ, code))
            live_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        event_type  <= typ;
        event_code  <= code;
        event_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(logic scale, logic [11:0] w, logic [11:0] h, logic [7:0] thr);
        drain();
        put_reg(CFG_SCALE_ENABLE, {11'd0, scale});
        put_reg(CFG_SCREEN_WIDTH, w);
        put_reg(CFG_SCREEN_HEIGHT, h);
        put_reg(CFG_MOVE_THRESHOLD, {4'd0, thr});
        cfg_we <= 1'b0;
    endtask

    task automatic noise_event();
        case ($urandom_range(0, 2))
            0: send_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)),
                          12'($urandom_range(0, 4095)));
            1: send_event(EVT_ABS, 10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)));
            default: send_event(EVT_KEY, 10'($urandom_range(0, 1023)),
                                12'($urandom_range(0, 4095)));
        endcase
    endtask

    // Mostly small steps around the last sample so both sides of the deadband get hit.
    task automatic move(logic [9:0] code);
        int last;
        int step;
        int v;
        last = (code == CODE_X) ? last_x : last_y;
        if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 4095);
        else
        begin
            step = $urandom_range(0, 2 * int'(tracker.thresh) + 8);
            v = $urandom_range(0, 1) ? last + step : last - step;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
        end
        if (code == CODE_X)
            last_x = v;
        else
            last_y = v;
        send_event(EVT_ABS, code, 12'(v));
    endtask

    task automatic gesture();
        int frames;
        frames      = $urandom_range(1, 6);
        send_steady = ($urandom_range(0, 3) == 0);
        take_steady = ($urandom_range(0, 3) == 0);
        send_event(EVT_KEY, CODE_TOUCH, 12'($urandom_range(1, 4095)));
        repeat (frames)
        begin
            if ($urandom_range(0, 3) != 0)
                move(CODE_X);
            if ($urandom_range(0, 3) != 0)
                move(CODE_Y);
            if ($urandom_range(0, 7) == 0)
                send_event(EVT_KEY, CODE_DTAP,
                           $urandom_range(0, 1) ? 12'($urandom_range(1, 4095)) : 12'd0);
            if ($urandom_range(0, 9) == 0)
                noise_event();
            send_event(EVT_SYNC,
                       $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1023)) : 10'd0,
                       $urandom_range(0, 3) == 0 ? 12'($urandom_range(0, 4095)) : 12'd0);
        end
        if ($urandom_range(0, 7) != 0)
            send_event(EVT_KEY, CODE_TOUCH, 12'd0);
        send_event(EVT_SYNC, 10'd0, 12'd0);
    endtask

    task automatic random_phase();
        live_sent = 0;
        while (live_sent < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                noise_event();
            else
                gesture();
        end
    endtask

    initial
    begin
        tracker     = new();
        errors      = 0;
        idle_cycles = 0;
        send_steady = 0;
        take_steady = 0;
        last_x      = 0;
        last_y      = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        event_type  = '0;
        event_code  = '0;
        event_value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, deadband edges, drag, double tap, ignored events.
        send_event(EVT_ABS, CODE_X, 12'd4095);
        send_event(EVT_ABS, CODE_Y, 12'd0);
        send_event(EVT_ABS, CODE_Y, 12'd11);
        send_event(EVT_ABS, CODE_X, 12'd4085);
        send_event(EVT_ABS, CODE_X, 12'd4084);
        send_event(EVT_KEY, CODE_TOUCH, 12'd1);
        send_event(EVT_SYNC, 10'd0, 12'd0);
        send_event(EVT_ABS, CODE_X, 12'd100);
        send_event(EVT_SYNC, 10'd1023, 12'd4095);
        send_event(EVT_SYNC, 10'd0, 12'd0);
        send_event(EVT_KEY, CODE_DTAP, 12'd4095);
        send_event(EVT_ABS, CODE_Y, 12'd2000);
        send_event(EVT_SYNC, 10'd0, 12'd0);
        send_event(EVT_KEY, CODE_DTAP, 12'd0);
        send_event(EVT_SYNC, 10'd0, 12'd0);
        send_event(EVT_ABS, CODE_X, 12'd3000);
        send_event(EVT_SYNC, 10'd0, 12'd0);
        send_event(EVT_KEY, CODE_TOUCH, 12'd0);
        send_event(5'd2, CODE_X, 12'd500);
        send_event(5'd31, 10'd1023, 12'd4095);
        send_event(EVT_ABS, CODE_TOUCH, 12'd700);
        send_event(EVT_KEY, CODE_X, 12'd1);
        send_event(EVT_ABS, 10'd0, 12'd0);
        send_event(EVT_SYNC, 10'd0, 12'd0);

        configure(1'b0, 12'd600, 12'd800, 8'd0);
        random_phase();
        configure(1'b1, 12'd4095, 12'd4095, 8'd255);
        random_phase();
        configure(1'b1, 12'd1, 12'd1, 8'd0);
        random_phase();
        configure(1'b1, 12'd0, 12'd0, 8'd3);
        random_phase();
        configure(1'b0, 12'd4095, 12'd1, 8'd255);
        random_phase();
        repeat (3)
        begin
            configure(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
            random_phase();
        end

        drain();
        if (errors == 0)
            $display("touch_event_to_pointer_unit test passed");
        else
            $display("touch_event_to_pointer_unit test failed");
        $finish;
    end

endmodule
